// File: hw/rtl/rbfe_pkg.sv
// Shared types and constants of the ring buffer frame extractor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rbfe_pkg;

	localparam int DEPTH_DEF      = 128;
	localparam int MAX_HEADER_DEF = 4;
	localparam int MAX_WORDS_DEF  = 16;
	localparam int CMDQ_DEPTH     = 4;
	localparam int OUT_TDATA_W    = 40;
	localparam int CFG_INDEX_W    = 3;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_POP     = 2'd1;
	localparam logic [1:0] OP_EXTRACT = 2'd2;
	localparam logic [1:0] OP_RSVD    = 2'd3;

	localparam logic [1:0] ST_BYTE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_WORD  = 2'd2;
	localparam logic [1:0] ST_NOHDR = 2'd3;

	localparam logic [1:0] WS_8    = 2'd0;
	localparam logic [1:0] WS_16   = 2'd1;
	localparam logic [1:0] WS_32   = 2'd2;
	localparam logic [1:0] WS_RSVD = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTES  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LENGTH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WORD_COUNT    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WORD_SIZE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN    = 3'd4;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] header_bytes;
		logic [2:0]  header_length;
		logic [4:0]  word_count;
		logic [1:0]  word_size;
		logic        big_endian;
	} cfg_t;

endpackage

// File: hw/rtl/ring_buffer_frame_extractor_unit.sv
// Top level of the ring buffer frame extractor: configuration registers,
// front end, command queue and execution engine. Depends on rbfe_pkg.
//
//   Channel  Dir  Handshake             Payload
//   s_*      in   s_tvalid / s_tready   tdata: byte_in; tuser: opcode
//   m_*      out  m_tvalid / m_tready   tdata: value, not_empty; tuser: status; tlast
//   cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A push is done in the idle state and a pop goes through the pop state. An extract
// scans for the header, then assembles the data bytes, each byte read through the
// registered read port of the store; a reserved word size gives a no-header result.
// A stalled result beat holds the engine. Reset clears all control state; the store
// itself is not cleared. Commands wait in the front register and a four-entry queue,
// so up to five beats are taken while the engine works or the output stalls.
`timescale 1ns / 1ps

module ring_buffer_frame_extractor_unit
	import rbfe_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int MAX_HEADER = MAX_HEADER_DEF,
	parameter int MAX_WORDS  = MAX_WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // byte_in
	input  logic [1:0]             s_tuser,   // opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // value[31:0], not_empty, zero fill
	output logic [1:0]             m_tuser,   // status
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	cfg_t cfg_q;
	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic eng_valid;
	logic eng_ready;
	cmd_t eng_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_bytes  <= '0;
			cfg_q.header_length <= 3'd1;
			cfg_q.word_count    <= 5'd1;
			cfg_q.word_size     <= WS_8;
			cfg_q.big_endian    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEADER_BYTES:  cfg_q.header_bytes  <= cfg_data;
				REG_HEADER_LENGTH: cfg_q.header_length <= cfg_data[2:0];
				REG_WORD_COUNT:    cfg_q.word_count    <= cfg_data[4:0];
				REG_WORD_SIZE:     cfg_q.word_size     <= cfg_data[1:0];
				REG_BIG_ENDIAN:    cfg_q.big_endian    <= cfg_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	rbfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (front_valid),
		.q_ready  (front_ready),
		.q_cmd    (front_cmd)
	);

	rbfe_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (eng_valid),
		.out_ready (eng_ready),
		.out_cmd   (eng_cmd)
	);

	rbfe_back #(
		.DEPTH      (DEPTH),
		.MAX_HEADER (MAX_HEADER),
		.MAX_WORDS  (MAX_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (eng_valid),
		.cmd_ready (eng_ready),
		.cmd       (eng_cmd),
		.cfg       (cfg_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: hw/rtl/rbfe_front.sv
// Front end: accepts command beats, drops reserved opcodes and stages
// the rest for the command queue. Depends on rbfe_pkg.
`timescale 1ns / 1ps

module rbfe_front
	import rbfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // byte_in
	input  logic [1:0] s_tuser,   // opcode
	output logic       q_valid,
	input  logic       q_ready,
	output cmd_t       q_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;

	assign s_tready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_cmd    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= (s_tuser != OP_RSVD);
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.op   <= s_tuser;
			cmd_s1.data <= s_tdata;
		end
	end

endmodule

// File: hw/rtl/rbfe_cmd_queue.sv
// Short command queue between the front end and the execution engine.
// Depends on rbfe_pkg for the command type and depth.
`timescale 1ns / 1ps

module rbfe_cmd_queue
	import rbfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	localparam int PW = $clog2(CMDQ_DEPTH);

	cmd_t        slot_q [CMDQ_DEPTH];
	logic [PW:0] wr_ptr_q;
	logic [PW:0] rd_ptr_q;

	assign out_valid = (wr_ptr_q != rd_ptr_q);
	assign in_ready  = (wr_ptr_q[PW-1:0] != rd_ptr_q[PW-1:0]) || (wr_ptr_q[PW] == rd_ptr_q[PW]);
	assign out_cmd   = slot_q[rd_ptr_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_valid && out_ready) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			slot_q[wr_ptr_q[PW-1:0]] <= in_cmd;
		end
	end

endmodule

// File: hw/rtl/rbfe_back.sv
// Execution engine: byte store, ring indices, header scan, word assembly
// and the result register. Depends on rbfe_pkg.
`timescale 1ns / 1ps

module rbfe_back
	import rbfe_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int MAX_HEADER = MAX_HEADER_DEF,
	parameter int MAX_WORDS  = MAX_WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_t                   cmd,
	input  cfg_t                   cfg,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	localparam int IW  = $clog2(DEPTH);
	localparam int OW  = $clog2(DEPTH + 1);
	localparam int HW  = $clog2(MAX_HEADER + 1);
	localparam int WW  = $clog2(MAX_WORDS + 1);
	localparam int WIN = 8 * MAX_HEADER;
	localparam int TW  = WW + 2;
	localparam int CW  = (OW > TW) ? OW : TW;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_POP     = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_SCAN_RD = 3'd3;
	localparam logic [2:0] S_DATA    = 3'd4;
	localparam logic [2:0] S_DATA_RD = 3'd5;
	localparam logic [2:0] S_EMIT    = 3'd6;
	localparam logic [2:0] S_FAIL    = 3'd7;

	logic [7:0]     mem [DEPTH];
	logic [7:0]     mem_q;
	logic [2:0]     state_q;
	logic [IW-1:0]  wr_q;
	logic [IW-1:0]  rd_q;
	logic [OW-1:0]  occ_q;
	logic [HW-1:0]  len_q;
	logic [WW-1:0]  words_q;
	logic [1:0]     ws_q;
	logic           be_q;
	logic [WIN-1:0] expect_q;
	logic [WIN-1:0] mask_q;
	logic [WIN-1:0] win_q;
	logic [HW-1:0]  seen_q;
	logic [OW-1:0]  scan_q;
	logic [1:0]     j_q;
	logic [WW-1:0]  k_q;
	logic [31:0]    word_q;
	logic           ne_q;
	logic           out_valid_q;
	logic [31:0]    out_value_q;
	logic [1:0]     out_status_q;
	logic           out_last_q;
	logic           out_ne_q;

	logic           can_emit;
	logic           emit;
	logic           push_we;
	logic           has_byte;
	logic [7:0]     byte_rd;
	logic [IW-1:0]  rd_inc;
	logic [IW-1:0]  wr_inc;
	logic [OW-1:0]  occ_dec;
	logic [HW-1:0]  len_c;
	logic [WW-1:0]  words_c;
	logic [WIN-1:0] expect_c;
	logic [WIN-1:0] mask_c;
	logic [WIN-1:0] win_n;
	logic [HW-1:0]  seen_n;
	logic [OW-1:0]  scan_n;
	logic           found;
	logic           ne_final;
	logic [31:0]    word_n;
	logic [1:0]     j_last;
	logic           word_last;

	assign cmd_ready = (state_q == S_IDLE);
	assign can_emit  = !out_valid_q || m_tready;
	assign emit      = can_emit && (state_q == S_POP || state_q == S_EMIT
		|| state_q == S_FAIL);
	assign push_we   = (state_q == S_IDLE) && cmd_valid && (cmd.op == OP_PUSH);
	assign has_byte  = (occ_q != '0);
	assign byte_rd   = has_byte ? mem_q : 8'd0;
	assign rd_inc    = (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign wr_inc    = (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
	assign occ_dec   = has_byte ? occ_q - 1'b1 : occ_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - 33){1'b0}}, out_ne_q, out_value_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		int kk;
		kk = 0;
		if (cfg.header_length == '0) begin
			len_c = HW'(1);
		end else if (int'(cfg.header_length) > MAX_HEADER) begin
			len_c = HW'(MAX_HEADER);
		end else begin
			len_c = HW'(cfg.header_length);
		end
		if (cfg.word_count == '0) begin
			words_c = WW'(1);
		end else if (int'(cfg.word_count) > MAX_WORDS) begin
			words_c = WW'(MAX_WORDS);
		end else begin
			words_c = WW'(cfg.word_count);
		end
		expect_c = '0;
		mask_c   = '0;
		for (int i = 0; i < MAX_HEADER; i++) begin
			if (i < int'(len_c)) begin
				kk = int'(len_c) - 1 - i;
				expect_c[8*i +: 8] = (kk < 4) ? 8'(cfg.header_bytes >> (8 * kk)) : 8'd0;
				mask_c[8*i +: 8]   = 8'hFF;
			end
		end
	end

	always_comb begin
		win_n    = WIN'({win_q, byte_rd});
		seen_n   = (seen_q < len_q) ? seen_q + 1'b1 : seen_q;
		scan_n   = scan_q + 1'b1;
		found    = (seen_n >= len_q) && ((win_n & mask_q) == expect_q);
		ne_final = CW'(occ_dec) > (CW'(words_q) << ws_q);
		if (be_q) begin
			word_n = {word_q[23:0], byte_rd};
		end else begin
			word_n = word_q | (32'(byte_rd) << (5'd8 * j_q));
		end
		case (ws_q)
			WS_8:    j_last = 2'd0;
			WS_16:   j_last = 2'd1;
			default: j_last = 2'd3;
		endcase
		word_last = (WW'(k_q + 1'b1) == words_q);
	end

	always_ff @(posedge clk) begin
		if (push_we) begin
			mem[wr_q] <= cmd.data;
		end
		mem_q <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_q        <= '0;
			rd_q        <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_PUSH: begin
								wr_q <= wr_inc;
								if (occ_q == OW'(DEPTH)) begin
									rd_q <= wr_inc;
								end else begin
									occ_q <= occ_q + 1'b1;
								end
							end
							OP_POP: begin
								state_q <= S_POP;
							end
							OP_EXTRACT: begin
								state_q <= (cfg.word_size == WS_RSVD) ? S_FAIL : S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_POP: begin
					if (can_emit) begin
						rd_q        <= has_byte ? rd_inc : rd_q;
						occ_q       <= occ_dec;
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					rd_q  <= has_byte ? rd_inc : rd_q;
					occ_q <= occ_dec;
					if (found) begin
						state_q <= S_DATA_RD;
					end else if (scan_n == OW'(DEPTH)) begin
						state_q <= S_FAIL;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				S_DATA: begin
					rd_q    <= has_byte ? rd_inc : rd_q;
					occ_q   <= occ_dec;
					state_q <= (j_q == j_last) ? S_EMIT : S_DATA_RD;
				end
				S_DATA_RD: begin
					state_q <= S_DATA;
				end
				S_EMIT: begin
					if (can_emit) begin
						state_q     <= word_last ? S_IDLE : S_DATA;
					end
				end
				S_FAIL: begin
					if (can_emit) begin
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				len_q    <= len_c;
				words_q  <= words_c;
				ws_q     <= cfg.word_size;
				be_q     <= cfg.big_endian;
				expect_q <= expect_c;
				mask_q   <= mask_c;
				win_q    <= '0;
				seen_q   <= '0;
				scan_q   <= '0;
			end
			S_POP: begin
				if (can_emit) begin
					out_value_q  <= 32'(byte_rd);
					out_status_q <= has_byte ? ST_BYTE : ST_EMPTY;
					out_last_q   <= 1'b1;
					out_ne_q     <= (occ_dec != '0);
				end
			end
			S_SCAN: begin
				win_q  <= win_n;
				seen_q <= seen_n;
				scan_q <= scan_n;
				ne_q   <= ne_final;
				j_q    <= '0;
				k_q    <= '0;
				word_q <= '0;
			end
			S_DATA: begin
				word_q <= word_n;
				j_q    <= j_q + 1'b1;
			end
			S_EMIT: begin
				if (can_emit) begin
					out_value_q  <= word_q;
					out_status_q <= ST_WORD;
					out_last_q   <= word_last;
					out_ne_q     <= ne_q;
					k_q          <= k_q + 1'b1;
					j_q          <= '0;
					word_q       <= '0;
				end
			end
			S_FAIL: begin
				if (can_emit) begin
					out_value_q  <= '0;
					out_status_q <= ST_NOHDR;
					out_last_q   <= 1'b1;
					out_ne_q     <= has_byte;
				end
			end
			default: begin
				win_q <= win_q;
			end
		endcase
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= DEPTH)
		else $error("occupancy exceeds the store depth");

	a_empty_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == OW'(DEPTH)) |-> (rd_q == wr_q))
		else $error("ring indices disagree with occupancy");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_EMPTY) |-> (out_value_q == '0 && !out_ne_q))
		else $error("read of empty store returned data");

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_NOHDR || out_status_q == ST_BYTE
			|| out_status_q == ST_EMPTY)) |-> out_last_q)
		else $error("single-result beat not marked last");

	a_busy_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd_ready)
		else $error("engine took a command while busy");

endmodule
